>>> hw/rtl/dma8_pkg.sv
// shared types, codes and pattern tables of the eight channel dma engine
`default_nettype none

package dma8_pkg;

  localparam int CHAN_W = 3;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_START = 2'd2,
    REQ_TICK  = 2'd3
  } req_code_t;

  localparam logic [2:0] OFF_PARAMS = 3'd0;
  localparam logic [2:0] OFF_BPORT  = 3'd1;
  localparam logic [2:0] OFF_ALO    = 3'd2;
  localparam logic [2:0] OFF_AHI    = 3'd3;
  localparam logic [2:0] OFF_ABANK  = 3'd4;
  localparam logic [2:0] OFF_CLO    = 3'd5;
  localparam logic [2:0] OFF_CHI    = 3'd6;

  localparam logic [1:0] STEP_INC = 2'd0;
  localparam logic [1:0] STEP_DEC = 2'd2;

  localparam logic [2:0] MODE_1   = 3'd1;
  localparam logic [2:0] MODE_2   = 3'd2;
  localparam logic [2:0] MODE_3   = 3'd3;
  localparam logic [2:0] MODE_4   = 3'd4;
  localparam logic [2:0] MODE_MAX = 3'd4;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [CHAN_W-1:0] chan_sel;
    logic [2:0]        reg_offset;
    logic [7:0]        write_data;
  } req_t;

  typedef struct packed {
    logic              xfer_valid;
    logic [23:0]       a_address;
    logic [7:0]        b_port;
    logic              b_to_a;
    logic [CHAN_W-1:0] xfer_channel;
    logic              last_xfer;
    logic              busy_res;
    logic [7:0]        read_data;
  } res_t;

  // one channel's register set, kept as a single memory word
  typedef struct packed {
    logic [7:0]  params;
    logic [7:0]  b_port;
    logic [23:0] a_base;
    logic [15:0] count;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [CHAN_W-1:0] chan;
    entry_t            ent;
  } mem_wr_t;

  // b port offset of the mode pattern at a given position
  function automatic logic [1:0] pat_off(input logic [2:0] mode, input logic [1:0] pos);
    logic [1:0] r;
    case (mode)
      MODE_1:  r = {1'b0, pos[0]};
      MODE_3:  r = {1'b0, pos[1]};
      MODE_4:  r = pos;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // pattern length minus one, used as a wrap mask
  function automatic logic [1:0] pat_mask(input logic [2:0] mode);
    logic [1:0] r;
    case (mode)
      MODE_1, MODE_2: r = 2'd1;
      MODE_3, MODE_4: r = 2'd3;
      default:        r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dma8_if.sv
// request and result channel interfaces of the dma engine
`default_nettype none

interface dma8_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [2:0] chan_sel;
  logic [2:0] reg_offset;
  logic [7:0] write_data;

  modport source (output valid, req_type, chan_sel, reg_offset, write_data, input ready);
  modport sink   (input valid, req_type, chan_sel, reg_offset, write_data, output ready);
endinterface

interface dma8_res_if;
  logic        valid;
  logic        ready;
  logic        xfer_valid;
  logic [23:0] a_address;
  logic [7:0]  b_port;
  logic        b_to_a;
  logic [2:0]  xfer_channel;
  logic        last_xfer;
  logic        busy_res;
  logic [7:0]  read_data;

  modport source (output valid, xfer_valid, a_address, b_port, b_to_a, xfer_channel,
                  last_xfer, busy_res, read_data, input ready);
  modport sink   (input valid, xfer_valid, a_address, b_port, b_to_a, xfer_channel,
                  last_xfer, busy_res, read_data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/dma8_chan_mem.sv
// channel register file memory with valid bits and write-to-read forwarding
`default_nettype none

module dma8_chan_mem #(
  parameter int NUM_CHANNELS = 8,
  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          rd_en,
  input  wire logic [dma8_pkg::CHAN_W-1:0]   rd_chan,
  input  wire dma8_pkg::mem_wr_t             wr,
  output dma8_pkg::entry_t                   ent
);

  dma8_pkg::entry_t mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld;
  dma8_pkg::entry_t rdata;
  dma8_pkg::entry_t byp_ent;
  logic rvld;
  logic byp;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.chan[CW-1:0]] <= wr.ent;
    end
    if (rd_en) begin
      rdata   <= mem[rd_chan[CW-1:0]];
      byp_ent <= wr.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      rvld <= 1'b0;
      byp  <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.chan[CW-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        rvld <= vld[rd_chan[CW-1:0]];
        // same entry written on the read edge: take the new word
        byp  <= wr.en && (wr.chan == rd_chan);
      end
    end
  end

  assign ent = byp ? byp_ent : (rvld ? rdata : '0);

endmodule

`default_nettype wire

>>> hw/rtl/dma8_seq.sv
// request decode, transfer sequencing and channel scheduling
`default_nettype none

module dma8_seq #(
  parameter int NUM_CHANNELS = 8,
  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          acc,
  input  wire dma8_pkg::req_t                acc_req,
  input  wire logic                          s1_fire,
  input  wire dma8_pkg::entry_t              ent,
  output logic [dma8_pkg::CHAN_W-1:0]        rd_chan,
  output dma8_pkg::mem_wr_t                  wr,
  output dma8_pkg::res_t                     res
);

  dma8_pkg::req_t s1_req;

  logic                    active;
  logic [CW-1:0]           cur;
  logic [1:0]              pos;
  logic [23:0]             waddr;
  logic                    fresh;
  logic [NUM_CHANNELS-1:0] pending;
  logic [NUM_CHANNELS-1:0] elig;

  logic                    active_next;
  logic [CW-1:0]           cur_next;
  logic [1:0]              pos_next;
  logic [23:0]             waddr_next;
  logic                    fresh_next;
  logic [NUM_CHANNELS-1:0] pending_next;
  logic [NUM_CHANNELS-1:0] elig_next;

  logic                    adv_start;
  logic [NUM_CHANNELS-1:0] adv_src;
  logic [NUM_CHANNELS-1:0] adv_cand;
  logic [NUM_CHANNELS-1:0] adv_rest;
  logic                    adv_found;
  logic [CW-1:0]           adv_pick;

  logic                    chan_ok;
  logic                    acc_chan_ok;
  logic [CW-1:0]           w_idx;
  logic                    w_en;
  dma8_pkg::entry_t        e_new;
  logic [2:0]              mode;
  logic [1:0]              step;
  logic [23:0]             addr_cur;
  logic [15:0]             cnt_new;
  logic [CW-1:0]           cur_rd;

  assign chan_ok     = {1'b0, s1_req.chan_sel} < 4'(NUM_CHANNELS);
  assign acc_chan_ok = {1'b0, acc_req.chan_sel} < 4'(NUM_CHANNELS);
  assign mode        = ent.params[2:0];
  assign step        = ent.params[4:3];
  assign addr_cur    = fresh ? ent.a_base : waddr;
  assign cnt_new     = ent.count - 16'd1;

  // lowest eligible channel of the start mask on a start, else of the pending set
  assign adv_start = (s1_req.req_type == dma8_pkg::REQ_START);
  assign adv_src   = adv_start ? s1_req.write_data[NUM_CHANNELS-1:0] : pending;
  assign adv_cand  = adv_src & elig;

  always_comb begin
    adv_found = 1'b0;
    adv_pick  = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (adv_cand[i]) begin
        adv_found = 1'b1;
        adv_pick  = CW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      adv_rest[i] = adv_src[i] && adv_found && (i > int'(adv_pick));
    end
  end

  always_comb begin
    active_next  = active;
    cur_next     = cur;
    pos_next     = pos;
    waddr_next   = waddr;
    fresh_next   = fresh;
    pending_next = pending;
    w_en         = 1'b0;
    w_idx        = cur;
    e_new        = ent;
    res          = '0;

    case (s1_req.req_type)
      dma8_pkg::REQ_WRITE: begin
        w_idx = s1_req.chan_sel[CW-1:0];
        if (!active && chan_ok) begin
          w_en = 1'b1;
          case (s1_req.reg_offset)
            dma8_pkg::OFF_PARAMS: e_new.params        = s1_req.write_data;
            dma8_pkg::OFF_BPORT:  e_new.b_port        = s1_req.write_data;
            dma8_pkg::OFF_ALO:    e_new.a_base[7:0]   = s1_req.write_data;
            dma8_pkg::OFF_AHI:    e_new.a_base[15:8]  = s1_req.write_data;
            dma8_pkg::OFF_ABANK:  e_new.a_base[23:16] = s1_req.write_data;
            dma8_pkg::OFF_CLO:    e_new.count[7:0]    = s1_req.write_data;
            dma8_pkg::OFF_CHI:    e_new.count[15:8]   = s1_req.write_data;
            default:              w_en                = 1'b0;
          endcase
        end
      end
      dma8_pkg::REQ_READ: begin
        if (chan_ok) begin
          case (s1_req.reg_offset)
            dma8_pkg::OFF_PARAMS: res.read_data = ent.params;
            dma8_pkg::OFF_BPORT:  res.read_data = ent.b_port;
            dma8_pkg::OFF_ALO:    res.read_data = ent.a_base[7:0];
            dma8_pkg::OFF_AHI:    res.read_data = ent.a_base[15:8];
            dma8_pkg::OFF_ABANK:  res.read_data = ent.a_base[23:16];
            dma8_pkg::OFF_CLO:    res.read_data = ent.count[7:0];
            dma8_pkg::OFF_CHI:    res.read_data = ent.count[15:8];
            default:              res.read_data = 8'd0;
          endcase
        end
      end
      dma8_pkg::REQ_START: begin
        if (!active) begin
          active_next  = adv_found;
          pending_next = adv_rest;
          if (adv_found) begin
            cur_next   = adv_pick;
            pos_next   = 2'd0;
            fresh_next = 1'b1;
          end
        end
      end
      default: begin
        if (active) begin
          res.xfer_valid   = 1'b1;
          res.a_address    = addr_cur;
          res.b_port       = ent.b_port + {6'd0, dma8_pkg::pat_off(mode, pos)};
          res.b_to_a       = ent.params[7];
          res.xfer_channel = dma8_pkg::CHAN_W'(cur);
          case (step)
            dma8_pkg::STEP_INC: waddr_next = addr_cur + 24'd1;
            dma8_pkg::STEP_DEC: waddr_next = addr_cur - 24'd1;
            default:            waddr_next = addr_cur;
          endcase
          fresh_next  = 1'b0;
          pos_next    = (pos + 2'd1) & dma8_pkg::pat_mask(mode);
          w_en        = 1'b1;
          e_new.count = cnt_new;
          if (cnt_new == 16'd0) begin
            active_next  = adv_found;
            pending_next = adv_rest;
            res.last_xfer = !adv_found;
            if (adv_found) begin
              cur_next   = adv_pick;
              pos_next   = 2'd0;
              fresh_next = 1'b1;
            end
          end
        end
      end
    endcase

    res.busy_res = active_next;
  end

  always_comb begin
    elig_next = elig;
    if (w_en) begin
      elig_next[w_idx] = (e_new.count != 16'd0) && (e_new.params[2:0] <= dma8_pkg::MODE_MAX);
    end
  end

  assign wr.en  = s1_fire && w_en;
  assign wr.chan = dma8_pkg::CHAN_W'(w_idx);
  assign wr.ent = e_new;

  // read address for the item entering now: ticks follow the channel that
  // is current once the item ahead has retired
  assign cur_rd  = s1_fire ? cur_next : cur;
  assign rd_chan = (acc_req.req_type == dma8_pkg::REQ_TICK) ? dma8_pkg::CHAN_W'(cur_rd)
                 : (acc_chan_ok ? acc_req.chan_sel : '0);

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_req <= acc_req;
    end
    waddr <= s1_fire ? waddr_next : waddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      cur     <= '0;
      pos     <= 2'd0;
      fresh   <= 1'b0;
      pending <= '0;
      elig    <= '0;
    end else if (s1_fire) begin
      active  <= active_next;
      cur     <= cur_next;
      pos     <= pos_next;
      fresh   <= fresh_next;
      pending <= pending_next;
      elig    <= elig_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/eight_channel_dma_engine_top.sv
// top level of the eight channel dma transfer sequencer
`default_nettype none

// Eight channel DMA transfer sequencer. Requests on req program or read a
// channel's registers, start a channel mask, or tick; every request gives
// exactly one result on res. A tick while a DMA runs issues one byte
// transfer (A address, B port from the mode pattern, direction, channel),
// channels running in ascending order; last_xfer marks the final byte.
// Rate: one request per clock sustained while res is ready. Stage one holds
// the accepted request; the result register is loaded when stage one
// retires. Each request does one read-modify-write of its channel's entry
// in the register-file memory (read at acceptance, written back when stage
// one retires); a back-to-back access to the same entry is forwarded. Entry
// valid bits are cleared by reset, so no clearing pass is needed.
module eight_channel_dma_engine_top #(
  parameter int NUM_CHANNELS = 8
) (
  input wire logic clk,
  input wire logic rst,
  dma8_req_if.sink   req,
  dma8_res_if.source res
);

  logic                 s1_valid;
  logic                 s1_fire;
  logic                 acc;
  logic                 out_valid;
  dma8_pkg::req_t       acc_req;
  dma8_pkg::res_t       s1_res;
  dma8_pkg::res_t       out_res;
  dma8_pkg::entry_t     ent;
  dma8_pkg::mem_wr_t    wr;
  logic [dma8_pkg::CHAN_W-1:0] rd_chan;

  // stage one retires when the output register is free or being emptied
  assign s1_fire   = s1_valid && (!out_valid || res.ready);
  assign req.ready = !rst && (!s1_valid || s1_fire);
  assign acc       = req.valid && req.ready;

  assign acc_req.req_type   = req.req_type;
  assign acc_req.chan_sel   = req.chan_sel;
  assign acc_req.reg_offset = req.reg_offset;
  assign acc_req.write_data = req.write_data;

  // channel register file: one word per channel
  dma8_chan_mem #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (acc),
    .rd_chan (rd_chan),
    .wr      (wr),
    .ent     (ent)
  );

  // decode, transfer generation and channel scheduling
  dma8_seq #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .acc     (acc),
    .acc_req (acc_req),
    .s1_fire (s1_fire),
    .ent     (ent),
    .rd_chan (rd_chan),
    .wr      (wr),
    .res     (s1_res)
  );

  // stage one occupancy and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res <= s1_res;
    end
  end

  assign res.valid        = out_valid;
  assign res.xfer_valid   = out_res.xfer_valid;
  assign res.a_address    = out_res.a_address;
  assign res.b_port       = out_res.b_port;
  assign res.b_to_a       = out_res.b_to_a;
  assign res.xfer_channel = out_res.xfer_channel;
  assign res.last_xfer    = out_res.last_xfer;
  assign res.busy_res     = out_res.busy_res;
  assign res.read_data    = out_res.read_data;

  // a transfer either leaves the engine busy or is the final byte
  a_xfer_busy_or_last : assert property (@(posedge clk) disable iff (rst)
    res.valid && res.xfer_valid |-> res.busy_res || res.last_xfer)
    else $error("transfer neither busy nor last");

  // the final byte always ends the dma
  a_last_ends : assert property (@(posedge clk) disable iff (rst)
    res.valid && res.last_xfer |-> res.xfer_valid && !res.busy_res)
    else $error("last transfer with engine still busy");

  // no address, port or channel fields without a transfer
  a_idle_fields : assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.xfer_valid |->
      res.a_address == 24'd0 && res.b_port == 8'd0 && res.xfer_channel == 3'd0)
    else $error("transfer fields set without a transfer");

endmodule

`default_nettype wire

>>> verif/tb_eight_channel_dma_engine_top.sv
// self-checking testbench of the eight channel dma transfer sequencer
`timescale 1ns / 100ps

module tb_eight_channel_dma_engine_top;
  import dma8_pkg::*;

  localparam int CHANNELS    = 8;
  localparam int ITEM_TARGET = 800;

  // codes the package leaves unnamed
  localparam logic [2:0] OFF_NONE  = 3'd7;
  localparam logic [2:0] MODE_0    = 3'd0;
  localparam logic [2:0] MODE_RSVD = 3'd5;

  // running copy of the channel registers and the sequencer, plus the
  // transfer results it predicts, oldest first
  class dma_xfer_scoreboard;
    logic [7:0]  chan_ctrl[CHANNELS];
    logic [7:0]  chan_port[CHANNELS];
    logic [23:0] chan_base[CHANNELS];
    logic [15:0] chan_bytes[CHANNELS];
    logic [7:0]  queued_chans;
    bit          running;
    logic [2:0]  run_chan;
    logic [1:0]  run_pos;
    logic [23:0] run_addr;
    logic [1:0]  port_offset[5][4];
    logic [1:0]  pos_wrap[5];
    res_t        expected_q[$];
    int          errors;

    function new();
      port_offset = '{'{2'd0, 2'd0, 2'd0, 2'd0}, '{2'd0, 2'd1, 2'd0, 2'd1},
                      '{2'd0, 2'd0, 2'd0, 2'd0}, '{2'd0, 2'd0, 2'd1, 2'd1},
                      '{2'd0, 2'd1, 2'd2, 2'd3}};
      pos_wrap = '{2'd0, 2'd1, 2'd1, 2'd3, 2'd3};
      foreach (chan_ctrl[i]) begin
        chan_ctrl[i]  = '0;
        chan_port[i]  = '0;
        chan_base[i]  = '0;
        chan_bytes[i] = '0;
      end
      queued_chans = '0;
      running      = 1'b0;
      run_chan     = '0;
      run_pos      = '0;
      run_addr     = '0;
      errors       = 0;
    endfunction

    function bit busy();
      return running;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    // lowest queued channel with bytes left and a defined mode, else idle
    function void pick_next_channel();
      for (int i = 0; i < 8; i++) begin
        if (queued_chans[i]) begin
          queued_chans[i] = 1'b0;
          if (chan_bytes[i] != 16'd0 && chan_ctrl[i][2:0] <= MODE_MAX) begin
            run_chan = 3'(i);
            run_pos  = '0;
            run_addr = chan_base[i];
            running  = 1'b1;
            return;
          end
        end
      end
      running = 1'b0;
    endfunction

    function void note_request(req_t r);
      res_t       e;
      int         m;
      logic [2:0] c;
      logic [1:0] step;
      e = '0;
      c = r.chan_sel;
      case (req_code_t'(r.req_type))
        REQ_WRITE: begin
          if (!running && int'(c) < CHANNELS) begin
            case (r.reg_offset)
              OFF_PARAMS: chan_ctrl[c]         = r.write_data;
              OFF_BPORT:  chan_port[c]         = r.write_data;
              OFF_ALO:    chan_base[c][7:0]    = r.write_data;
              OFF_AHI:    chan_base[c][15:8]   = r.write_data;
              OFF_ABANK:  chan_base[c][23:16]  = r.write_data;
              OFF_CLO:    chan_bytes[c][7:0]   = r.write_data;
              OFF_CHI:    chan_bytes[c][15:8]  = r.write_data;
              default: ;
            endcase
          end
        end
        REQ_READ: begin
          if (int'(c) < CHANNELS) begin
            case (r.reg_offset)
              OFF_PARAMS: e.read_data = chan_ctrl[c];
              OFF_BPORT:  e.read_data = chan_port[c];
              OFF_ALO:    e.read_data = chan_base[c][7:0];
              OFF_AHI:    e.read_data = chan_base[c][15:8];
              OFF_ABANK:  e.read_data = chan_base[c][23:16];
              OFF_CLO:    e.read_data = chan_bytes[c][7:0];
              OFF_CHI:    e.read_data = chan_bytes[c][15:8];
              default:    e.read_data = '0;
            endcase
          end
        end
        REQ_START: begin
          if (!running) begin
            queued_chans = r.write_data & 8'((1 << CHANNELS) - 1);
            pick_next_channel();
          end
        end
        default: begin
          if (running) begin
            m = int'(chan_ctrl[run_chan][2:0]);
            if (m > int'(MODE_MAX)) m = 0;
            step           = chan_ctrl[run_chan][4:3];
            e.xfer_valid   = 1'b1;
            e.a_address    = run_addr;
            e.b_port       = chan_port[run_chan] + 8'(port_offset[m][run_pos]);
            e.b_to_a       = chan_ctrl[run_chan][7];
            e.xfer_channel = run_chan;
            if (step == STEP_INC) run_addr = run_addr + 24'd1;
            else if (step == STEP_DEC) run_addr = run_addr - 24'd1;
            run_pos = (run_pos + 2'd1) & pos_wrap[m];
            chan_bytes[run_chan] = chan_bytes[run_chan] - 16'd1;
            if (chan_bytes[run_chan] == 16'd0) begin
              pick_next_channel();
              if (!running) e.last_xfer = 1'b1;
            end
          end
        end
      endcase
      e.busy_res = running;
      expected_q.push_back(e);
    endfunction

    function void field_diff(string name, logic [23:0] want, logic [23:0] seen);
      if (seen !== want) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      field_diff("xfer_valid", 24'(e.xfer_valid), 24'(got.xfer_valid));
      field_diff("a_address", e.a_address, got.a_address);
      field_diff("b_port", 24'(e.b_port), 24'(got.b_port));
      field_diff("b_to_a", 24'(e.b_to_a), 24'(got.b_to_a));
      field_diff("xfer_channel", 24'(e.xfer_channel), 24'(got.xfer_channel));
      field_diff("last_xfer", 24'(e.last_xfer), 24'(got.last_xfer));
      field_diff("busy_res", 24'(e.busy_res), 24'(got.busy_res));
      field_diff("read_data", 24'(e.read_data), 24'(got.read_data));
    endfunction
  endclass

  logic clk;
  logic rst;

  dma8_req_if req_ch();
  dma8_res_if res_ch();

  eight_channel_dma_engine_top #(
    .NUM_CHANNELS(CHANNELS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  dma_xfer_scoreboard sb;
  int useful_items;
  bit sender_burst;
  bit receiver_burst;
  int results_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #(5_000_000);
    $display("tb_eight_channel_dma_engine_top: FAIL");
    $finish;
  end

  // one request transfer: random gap, then hold valid until the block takes it
  task automatic send_req(req_code_t kind, logic [2:0] ch, logic [2:0] off,
                          logic [7:0] data);
    req_t r;
    int   gap;
    r.req_type   = kind;
    r.chan_sel   = ch;
    r.reg_offset = off;
    r.write_data = data;
    // writes and starts while busy, and ticks while idle, are dropped by the block
    if (!(((kind == REQ_WRITE || kind == REQ_START) && sb.busy()) ||
          (kind == REQ_TICK && !sb.busy())))
      useful_items++;
    gap = sender_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.chan_sel   <= ch;
    req_ch.reg_offset <= off;
    req_ch.write_data <= data;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(r);
  endtask

  // keep ticking until the dma finishes, with reads and dropped requests mixed in
  task automatic drain_ticks();
    while (sb.busy()) begin
      case ($urandom_range(0, 9))
        7: send_req(REQ_READ, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 8'h00);
        8: send_req(REQ_WRITE, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                    8'($urandom));
        9: send_req(REQ_START, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                    8'($urandom));
        default: send_req(REQ_TICK, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                          8'($urandom));
      endcase
    end
  endtask

  // request side: directed checks, then random dma sequences and stray requests
  initial begin
    logic [7:0]  mask;
    logic [7:0]  ctrl;
    logic [7:0]  data;
    logic [23:0] base;
    logic [15:0] bytes;
    logic [2:0]  ch;
    logic [2:0]  off;
    req_code_t   kind;
    int          n;
    int          drain_wait;

    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_WRITE;
    req_ch.chan_sel   <= '0;
    req_ch.reg_offset <= '0;
    req_ch.write_data <= '0;
    sb           = new();
    useful_items = 0;
    sender_burst = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset contents and a tick with nothing running
    send_req(REQ_READ, 3'd0, OFF_PARAMS, 8'h00);
    send_req(REQ_TICK, 3'd0, OFF_PARAMS, 8'hFF);
    // offset seven holds nothing
    send_req(REQ_WRITE, 3'd3, OFF_NONE, 8'hFF);
    send_req(REQ_READ, 3'd3, OFF_NONE, 8'h00);
    // a start whose only channel has a reserved mode leaves the engine idle
    send_req(REQ_WRITE, 3'd6, OFF_PARAMS, {5'b00000, MODE_RSVD});
    send_req(REQ_WRITE, 3'd6, OFF_CLO, 8'h01);
    send_req(REQ_START, 3'd0, OFF_PARAMS, 8'h40);
    // channel 7: b to a, decrementing through zero, b port wrapping in mode 4
    send_req(REQ_WRITE, 3'd7, OFF_PARAMS, {1'b1, 2'b00, STEP_DEC, MODE_4});
    send_req(REQ_WRITE, 3'd7, OFF_BPORT, 8'hFF);
    send_req(REQ_WRITE, 3'd7, OFF_ALO, 8'h01);
    send_req(REQ_WRITE, 3'd7, OFF_CLO, 8'h03);
    // channel 5: incrementing across the top of the 24 bit space
    send_req(REQ_WRITE, 3'd5, OFF_PARAMS, {3'b000, STEP_INC, MODE_0});
    send_req(REQ_WRITE, 3'd5, OFF_ALO, 8'hFF);
    send_req(REQ_WRITE, 3'd5, OFF_AHI, 8'hFF);
    send_req(REQ_WRITE, 3'd5, OFF_ABANK, 8'hFF);
    send_req(REQ_WRITE, 3'd5, OFF_CLO, 8'h02);
    send_req(REQ_START, 3'd0, OFF_PARAMS, 8'hE0);
    // busy: write and start dropped, reads see count and programmed address
    send_req(REQ_WRITE, 3'd7, OFF_PARAMS, 8'h00);
    send_req(REQ_START, 3'd0, OFF_PARAMS, 8'hFF);
    send_req(REQ_READ, 3'd5, OFF_CLO, 8'h00);
    send_req(REQ_READ, 3'd5, OFF_ALO, 8'h00);
    repeat (5) send_req(REQ_TICK, 3'd0, OFF_PARAMS, 8'h00);

    while (useful_items < ITEM_TARGET) begin
      sender_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) begin
        // stray requests in any order
        repeat ($urandom_range(3, 10)) begin
          kind = req_code_t'($urandom_range(0, 3));
          ch   = 3'($urandom_range(0, 7));
          off  = 3'($urandom_range(0, 7));
          data = 8'($urandom);
          // keep idle counts small so that a later start ends in reasonable time
          if (kind == REQ_WRITE && off == OFF_CHI && !sb.busy()) data = data & 8'h01;
          send_req(kind, ch, off, data);
        end
      end else begin
        // well formed dma: program one to three channels, start, run to the end
        drain_ticks();
        mask = '0;
        n    = $urandom_range(1, 3);
        repeat (n) begin
          ch   = 3'($urandom_range(0, 7));
          ctrl = 8'($urandom);
          if ($urandom_range(0, 7) != 0) ctrl[2:0] = 3'($urandom_range(0, int'(MODE_MAX)));
          base = 24'($urandom);
          case ($urandom_range(0, 7))
            0: base = 24'hFFFFFF - 24'($urandom_range(0, 3));
            1: base = 24'($urandom_range(0, 3));
            default: ;
          endcase
          bytes = 16'($urandom_range(1, 6));
          case ($urandom_range(0, 15))
            0: bytes = 16'd0;
            1: bytes = {8'h01, 8'($urandom)};
            2: bytes[7:0] = 8'($urandom);
            default: ;
          endcase
          // full count high byte round trip before the real value goes in
          if ($urandom_range(0, 15) == 0) begin
            send_req(REQ_WRITE, ch, OFF_CHI, 8'hFF);
            send_req(REQ_READ, ch, OFF_CHI, 8'h00);
          end
          send_req(REQ_WRITE, ch, OFF_PARAMS, ctrl);
          send_req(REQ_WRITE, ch, OFF_BPORT, 8'($urandom));
          send_req(REQ_WRITE, ch, OFF_ALO, base[7:0]);
          send_req(REQ_WRITE, ch, OFF_AHI, base[15:8]);
          send_req(REQ_WRITE, ch, OFF_ABANK, base[23:16]);
          send_req(REQ_WRITE, ch, OFF_CLO, bytes[7:0]);
          send_req(REQ_WRITE, ch, OFF_CHI, bytes[15:8]);
          if ($urandom_range(0, 7) == 0) send_req(REQ_WRITE, ch, OFF_NONE, 8'($urandom));
          if ($urandom_range(0, 3) == 0)
            send_req(REQ_READ, ch, 3'($urandom_range(0, 7)), 8'h00);
          mask[ch] = 1'b1;
        end
        if ($urandom_range(0, 3) == 0) mask = mask | 8'($urandom);
        send_req(REQ_START, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), mask);
        drain_ticks();
        if ($urandom_range(0, 3) == 0)
          send_req(REQ_TICK, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 8'h00);
      end
    end

    req_ch.valid <= 1'b0;
    // let the remaining results come out, then idle before the final check
    drain_wait = 0;
    while (sb.outstanding() > 0 && drain_wait < 10000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb_eight_channel_dma_engine_top: PASS");
    end else begin
      if (sb.outstanding() != 0)
        $display("%0t: %0d expected results never arrived", $time, sb.outstanding());
      $display("tb_eight_channel_dma_engine_top: FAIL");
    end
    $finish;
  end

  // result side: random stalls, bursts with none, and one long hold-off
  initial begin
    res_t got;
    int   stall;
    res_ch.ready   <= 1'b0;
    receiver_burst = 1'b0;
    results_seen   = 0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      // long hold so the block backs up and stalls the request side
      if (results_seen == 200) stall = 300;
      else if (receiver_burst) stall = 0;
      else stall = $urandom_range(0, 10);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
      got.xfer_valid   = res_ch.xfer_valid;
      got.a_address    = res_ch.a_address;
      got.b_port       = res_ch.b_port;
      got.b_to_a       = res_ch.b_to_a;
      got.xfer_channel = res_ch.xfer_channel;
      got.last_xfer    = res_ch.last_xfer;
      got.busy_res     = res_ch.busy_res;
      got.read_data    = res_ch.read_data;
      sb.check_result(got);
      results_seen++;
      if (results_seen % 50 == 0) receiver_burst = ($urandom_range(0, 2) == 0);
    end
  end

endmodule
